>>> rtl/gzrs_pkg.sv
package gzrs_pkg;

   // Field and register widths
   localparam int STEP_BITS      = 8;
   localparam int INDEX_BITS     = STEP_BITS + 1;
   localparam int TICK_BITS      = 16;
   localparam int OFS_BITS       = 12;
   localparam int FWD_BITS       = 20;
   localparam int LAT_BITS       = 13;
   localparam int MODE_BITS      = 2;
   localparam int MAX_STEPS      = 255;

   localparam int REQ_DATA_BITS  = 8;
   localparam int RSP_DATA_BITS  = 40;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;

   localparam logic [FWD_BITS-1:0] FWD_MAX = '1;

   // Support modes
   localparam logic [MODE_BITS-1:0] SUPPORT_DOUBLE_LEFT  = 2'd0;
   localparam logic [MODE_BITS-1:0] SUPPORT_DOUBLE_RIGHT = 2'd1;
   localparam logic [MODE_BITS-1:0] SUPPORT_SINGLE_LEFT  = 2'd2;
   localparam logic [MODE_BITS-1:0] SUPPORT_SINGLE_RIGHT = 2'd3;

   // Register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SWAY_OFFSET    = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_STRIDE_LENGTH  = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_STARTUP_TICKS  = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DOUBLE_TICKS   = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SINGLE_TICKS   = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SHUTDOWN_TICKS = 3'd5;

   // Register reset values
   localparam logic [OFS_BITS-1:0]  SWAY_OFFSET_RST    = 12'd850;
   localparam logic [OFS_BITS-1:0]  STRIDE_LENGTH_RST  = 12'd1500;
   localparam logic [TICK_BITS-1:0] STARTUP_TICKS_RST  = 16'd200;
   localparam logic [TICK_BITS-1:0] DOUBLE_TICKS_RST   = 16'd20;
   localparam logic [TICK_BITS-1:0] SINGLE_TICKS_RST   = 16'd80;
   localparam logic [TICK_BITS-1:0] SHUTDOWN_TICKS_RST = 16'd200;

   typedef struct packed {
      logic [OFS_BITS-1:0]  sway_offset;
      logic [OFS_BITS-1:0]  stride_length;
      logic [TICK_BITS-1:0] startup_ticks;
      logic [TICK_BITS-1:0] double_ticks;
      logic [TICK_BITS-1:0] single_ticks;
      logic [TICK_BITS-1:0] shutdown_ticks;
   } cfg_type;

   typedef struct packed {
      logic                  walking;
      logic [INDEX_BITS-1:0] step_index;
      logic [STEP_BITS-1:0]  total_steps;
      logic                  in_single_phase;
      logic [TICK_BITS-1:0]  phase_ticks_left;
      logic [FWD_BITS-1:0]   forward_pos;
      logic [LAT_BITS-1:0]   lateral_pos;
      logic [MODE_BITS-1:0]  current_stance;
   } state_type;

   typedef struct packed {
      logic                 valid_res;
      logic [FWD_BITS-1:0]  zmp_forward;
      logic [LAT_BITS-1:0]  zmp_lateral;
      logic [MODE_BITS-1:0] support_mode;
      logic                 final_sample;
   } result_type;

endpackage

>>> rtl/gait_zmp_reference_sequencer.sv
// Walking-gait ZMP reference sequencer.
// Request channel (req_*): tuser is the action (0 tick, 1 start a walk),
// tdata carries the footstep count used on a start. Every request returns
// exactly one response on rsp_*: tuser set when it carries a trajectory
// sample (forward and lateral ZMP in 0.1 mm, support mode), tlast set on the
// last sample of the walk. Starts and ticks while idle answer with an
// all-zero response.
// A request is taken every cycle while req_tready is high; the whole phase
// update, including a closed-form jump over any run of zero-length phases,
// sits between the walk state and the response register. That jump holds
// the one 8x12 multiplier of the path.
// When the receiver stalls, the response register holds its value and
// req_tready drops until it drains; a waiting response and a new request
// move in the same cycle when rsp_tready is high.
// The csr_* port takes a register write every cycle; unknown indexes drop.
// Write registers only between walks or while no request is outstanding.
// Reset is synchronous: registers return to their defaults, the walk state
// goes idle and the response register empties. No clearing pass is needed.
module gait_zmp_reference_sequencer (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   input  logic [gzrs_pkg::REQ_DATA_BITS-1:0]       req_tdata,  // step_count[7:0]
   input  logic                                     req_tuser,  // action
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   // zmp_forward[19:0], zmp_lateral[32:20], support_mode[34:33], zero[39:35]
   output logic [gzrs_pkg::RSP_DATA_BITS-1:0]       rsp_tdata,
   output logic                                     rsp_tuser,  // valid_res
   output logic                                     rsp_tlast,  // final_sample
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [gzrs_pkg::CSR_INDEX_BITS-1:0]      csr_index,
   input  logic [gzrs_pkg::CSR_DATA_BITS-1:0]       csr_data
);
   import gzrs_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   state_type  state_ff, state_in;
   result_type res_ff, res_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       req_take;
   state_type  step_nxt;
   result_type step_res;

   assign csr_ready  = 1'b1;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_take   = req_tvalid && req_tready;

   gzrs_step u_step (
      .action     (req_tuser),
      .step_count (req_tdata[STEP_BITS-1:0]),
      .cfg        (cfg_ff),
      .cur        (state_ff),
      .nxt        (step_nxt),
      .res        (step_res)
   );

   // Register writes: drop any index outside the register list
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_SWAY_OFFSET:    cfg_in.sway_offset    = csr_data[OFS_BITS-1:0];
            CSR_STRIDE_LENGTH:  cfg_in.stride_length  = csr_data[OFS_BITS-1:0];
            CSR_STARTUP_TICKS:  cfg_in.startup_ticks  = csr_data[TICK_BITS-1:0];
            CSR_DOUBLE_TICKS:   cfg_in.double_ticks   = csr_data[TICK_BITS-1:0];
            CSR_SINGLE_TICKS:   cfg_in.single_ticks   = csr_data[TICK_BITS-1:0];
            CSR_SHUTDOWN_TICKS: cfg_in.shutdown_ticks = csr_data[TICK_BITS-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   // Advance the walk and load the response on each taken request
   assign state_in     = req_take ? step_nxt : state_ff;
   assign res_in       = req_take ? step_res : res_ff;
   assign rsp_valid_in = req_take ? 1'b1 : (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sway_offset    <= SWAY_OFFSET_RST;
         cfg_ff.stride_length  <= STRIDE_LENGTH_RST;
         cfg_ff.startup_ticks  <= STARTUP_TICKS_RST;
         cfg_ff.double_ticks   <= DOUBLE_TICKS_RST;
         cfg_ff.single_ticks   <= SINGLE_TICKS_RST;
         cfg_ff.shutdown_ticks <= SHUTDOWN_TICKS_RST;
         state_ff              <= '0;
         rsp_valid_ff          <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Response payload needs no reset
   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = res_ff.valid_res;
   assign rsp_tlast  = res_ff.final_sample;
   assign rsp_tdata  = {{(RSP_DATA_BITS-FWD_BITS-LAT_BITS-MODE_BITS){1'b0}},
                        res_ff.support_mode, res_ff.zmp_lateral, res_ff.zmp_forward};

endmodule

>>> rtl/gzrs_step.sv
module gzrs_step (
   input  logic                               action,
   input  logic [gzrs_pkg::STEP_BITS-1:0]     step_count,
   input  gzrs_pkg::cfg_type                  cfg,
   input  gzrs_pkg::state_type                cur,
   output gzrs_pkg::state_type                nxt,
   output gzrs_pkg::result_type               res
);
   import gzrs_pkg::*;

   // Phase search source: either a fresh start (start hold with no ticks) or
   // the phase that just ran out.
   logic [INDEX_BITS-1:0] adv_k;
   logic                  adv_single;
   logic [FWD_BITS-1:0]   adv_fwd;
   logic [LAT_BITS-1:0]   adv_lat;
   logic [MODE_BITS-1:0]  adv_stance;
   logic [STEP_BITS-1:0]  adv_n;
   logic [STEP_BITS-1:0]  count_sat;

   logic [INDEX_BITS-1:0] n_ext;
   logic [INDEX_BITS-1:0] nk;
   logic                  in_foot;
   logic                  next_is_foot;
   logic                  before_end;
   logic [OFS_BITS-1:0]   half_stride;
   logic [OFS_BITS-1:0]   add_one;
   logic [FWD_BITS:0]     fwd_one_sum;
   logic [FWD_BITS-1:0]   fwd_one;
   logic [STEP_BITS-1:0]  remain;
   logic                  first_left;
   logic [STEP_BITS-1:0]  full_cnt;
   logic [FWD_BITS-1:0]   full_prod;
   logic [OFS_BITS:0]     half_sum;
   logic [FWD_BITS:0]     run_sum;
   logic [FWD_BITS+1:0]   fwd_all_sum;
   logic [FWD_BITS-1:0]   fwd_all;
   logic [FWD_BITS-1:0]   end_fwd;
   logic [LAT_BITS-1:0]   sway_pos;
   logic [LAT_BITS-1:0]   lat_one;
   logic [MODE_BITS-1:0]  end_stance;
   state_type             adv_st;

   assign count_sat = (32'(step_count) > MAX_STEPS) ? STEP_BITS'(MAX_STEPS) : step_count;

   assign adv_k      = action ? '0 : cur.step_index;
   assign adv_single = action ? 1'b0 : cur.in_single_phase;
   assign adv_fwd    = action ? '0 : cur.forward_pos;
   assign adv_lat    = action ? '0 : cur.lateral_pos;
   assign adv_stance = action ? SUPPORT_DOUBLE_LEFT : cur.current_stance;
   assign adv_n      = action ? count_sat : cur.total_steps;

   assign n_ext        = {1'b0, adv_n};
   assign nk           = adv_k + INDEX_BITS'(1);
   assign in_foot      = !adv_single && (adv_k != '0) && (adv_k <= n_ext);
   assign next_is_foot = (nk <= n_ext);
   // The end hold itself has run out once the index is past the footsteps
   assign before_end   = (adv_k <= n_ext);

   // Entry into the next footstep
   assign half_stride = cfg.stride_length >> 1;
   assign add_one     = (nk == INDEX_BITS'(1) || nk == n_ext) ? half_stride
                                                              : cfg.stride_length;
   assign fwd_one_sum = {1'b0, adv_fwd} + (FWD_BITS+1)'(add_one);
   assign fwd_one     = fwd_one_sum[FWD_BITS] ? FWD_MAX : fwd_one_sum[FWD_BITS-1:0];

   // All remaining footsteps empty: sum their strides in closed form
   assign remain     = adv_n - adv_k[STEP_BITS-1:0];
   assign first_left = (adv_k == '0);
   assign full_cnt   = remain - (first_left ? STEP_BITS'(2) : STEP_BITS'(1));
   assign full_prod  = FWD_BITS'(full_cnt) * FWD_BITS'(cfg.stride_length);
   assign half_sum   = first_left ? {half_stride, 1'b0} : {1'b0, half_stride};
   assign run_sum    = (adv_n == STEP_BITS'(1)) ? (FWD_BITS+1)'(half_stride)
                       : (FWD_BITS+1)'(full_prod) + (FWD_BITS+1)'(half_sum);
   assign fwd_all_sum = {2'b00, adv_fwd} + {1'b0, run_sum};
   assign fwd_all     = (fwd_all_sum[FWD_BITS+1:FWD_BITS] != 2'b00) ? FWD_MAX
                                                            : fwd_all_sum[FWD_BITS-1:0];
   assign end_fwd     = next_is_foot ? fwd_all : adv_fwd;

   assign sway_pos   = {1'b0, cfg.sway_offset};
   assign lat_one    = nk[0] ? sway_pos : LAT_BITS'(0) - sway_pos;
   assign end_stance = adv_n[0] ? SUPPORT_DOUBLE_RIGHT : SUPPORT_DOUBLE_LEFT;

   // Find the next phase with at least one tick, or end the walk
   always_comb begin
      adv_st             = '0;
      adv_st.total_steps = adv_n;
      adv_st.walking     = 1'b1;
      if (in_foot && cfg.single_ticks != '0) begin
         adv_st.step_index       = adv_k;
         adv_st.in_single_phase  = 1'b1;
         adv_st.phase_ticks_left = cfg.single_ticks;
         adv_st.forward_pos      = adv_fwd;
         adv_st.lateral_pos      = adv_lat;
         adv_st.current_stance   = {1'b1, adv_stance[0]};
      end else if (next_is_foot && cfg.double_ticks != '0) begin
         adv_st.step_index       = nk;
         adv_st.phase_ticks_left = cfg.double_ticks;
         adv_st.forward_pos      = fwd_one;
         adv_st.lateral_pos      = lat_one;
         adv_st.current_stance   = nk[0] ? SUPPORT_DOUBLE_LEFT : SUPPORT_DOUBLE_RIGHT;
      end else if (next_is_foot && cfg.single_ticks != '0) begin
         adv_st.step_index       = nk;
         adv_st.in_single_phase  = 1'b1;
         adv_st.phase_ticks_left = cfg.single_ticks;
         adv_st.forward_pos      = fwd_one;
         adv_st.lateral_pos      = lat_one;
         adv_st.current_stance   = nk[0] ? SUPPORT_SINGLE_LEFT : SUPPORT_SINGLE_RIGHT;
      end else if (before_end && cfg.shutdown_ticks != '0) begin
         adv_st.step_index       = n_ext + INDEX_BITS'(1);
         adv_st.phase_ticks_left = cfg.shutdown_ticks;
         adv_st.forward_pos      = end_fwd;
         adv_st.current_stance   = end_stance;
      end else begin
         adv_st.walking          = 1'b0;
         adv_st.forward_pos      = end_fwd;
         adv_st.current_stance   = end_stance;
      end
   end

   always_comb begin
      nxt = cur;
      res = '0;
      if (action) begin
         if (cfg.startup_ticks != '0) begin
            nxt                  = '0;
            nxt.walking          = 1'b1;
            nxt.total_steps      = count_sat;
            nxt.phase_ticks_left = cfg.startup_ticks;
            nxt.current_stance   = SUPPORT_DOUBLE_LEFT;
         end else begin
            nxt = adv_st;
         end
      end else if (cur.walking) begin
         res.valid_res    = 1'b1;
         res.zmp_forward  = cur.forward_pos;
         res.zmp_lateral  = cur.lateral_pos;
         res.support_mode = cur.current_stance;
         if (cur.phase_ticks_left == TICK_BITS'(1)) begin
            nxt = adv_st;
         end else begin
            nxt.phase_ticks_left = cur.phase_ticks_left - TICK_BITS'(1);
         end
         res.final_sample = !nxt.walking;
      end
   end

endmodule

>>> rtl/gzrs_checker.sv
module gzrs_checker (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_tvalid,
   input  logic                                     req_tready,
   input  logic                                     req_tuser,
   input  logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   input  logic [gzrs_pkg::RSP_DATA_BITS-1:0]       rsp_tdata,
   input  logic                                     rsp_tuser,
   input  logic                                     rsp_tlast
);
   import gzrs_pkg::*;

   // Each taken request shows a response in the next cycle
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("request taken without a response next cycle");

   // A start request answers with an empty response
   a_start_empty: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser |=> !rsp_tuser && !rsp_tlast &&
                                               rsp_tdata == '0)
      else $error("start request gave a non-empty response");

   // The final flag only rides on a real sample
   a_last_is_sample: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser)
      else $error("final flag set on a response without a sample");

   // A stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
                                    $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled response changed");

endmodule

bind gait_zmp_reference_sequencer gzrs_checker u_gzrs_checker (.*);
